### rtl/lmbb_pkg.sv
// Shared types and constants for the linear message byte buffer.
// Depends on nothing; imported by the top level and the testbench.
`timescale 1ns / 1ps

package lmbb_pkg;

  // Fixed field widths of the item and result ports.
  localparam int CMD_W  = 4;
  localparam int DATA_W = 16;
  localparam int AMT_W  = 12;
  localparam int PTR_W  = 11;
  localparam int BYTE_W = 8;

  // Largest value a pointer or the capacity register can hold.
  localparam int PTR_MAX = (1 << PTR_W) - 1;

  // Default store depth and reset value of the capacity register.
  localparam int              DEPTH_DEF = 1024;
  localparam logic [PTR_W-1:0] BSIZE_RST = PTR_W'(1024);

  // Command codes carried by an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_BYTE    = 4'd0,
    CMD_PUT_WORD_LO = 4'd1,
    CMD_PUT_WORD_HI = 4'd2,
    CMD_GET_BYTE    = 4'd3,
    CMD_GET_WORD_LO = 4'd4,
    CMD_GET_WORD_HI = 4'd5,
    CMD_ADV_READ    = 4'd6,
    CMD_ADV_WRITE   = 4'd7,
    CMD_DISCARD     = 4'd8,
    CMD_SEARCH      = 4'd9,
    CMD_LOCATE      = 4'd10,
    CMD_CLEAR       = 4'd11
  } cmd_t;

endpackage

### rtl/linear_message_byte_buffer.sv
// Linear message byte buffer: top level with the command sequencer and pointers.
// Depends on lmbb_pkg and lmbb_ram.
// Item flow: put byte, advance, clear, a discard that moves nothing and any undefined code go from S_EXEC
// straight to S_OUT; put word adds S_PUT2, get byte S_GET1, get word S_GET1 and S_GET2; a compacting discard
// walks S_MOVE and search/locate S_SCAN, one store byte per cycle through the single read port.
// One item is in work at a time; the next is taken the cycle after its result is registered.
// Reset: synchronous; afterwards a clearing pass writes zeros over all DEPTH store
// entries, one per cycle, with in_ready low until the pass is done.
`timescale 1ns / 1ps

module linear_message_byte_buffer
  import lmbb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration port
  input  logic              cfg_wr_en,
  input  logic [PTR_W-1:0]  cfg_wr_data,
  // Input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [DATA_W-1:0] in_data_value,
  input  logic [AMT_W-1:0]  in_amount,
  // Result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_read_value,
  output logic [PTR_W-1:0]  out_position,
  output logic              out_found,
  output logic              out_dropped,
  output logic [PTR_W-1:0]  out_used_count,
  output logic [PTR_W-1:0]  out_free_count
);

  localparam int AW    = $clog2(DEPTH);
  localparam int SUM_W = AMT_W + 1;
  localparam logic [PTR_W-1:0] DEPTH_CAP = PTR_W'((DEPTH > PTR_MAX) ? PTR_MAX : DEPTH);
  localparam logic [AW-1:0]    CLR_LAST  = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EXEC, S_PUT2, S_GET1, S_GET2, S_MOVE, S_SCAN, S_OUT
  } state_t;

  state_t              state_r;
  logic [AW-1:0]       clr_addr_r;
  logic [PTR_W-1:0]    bsize_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [PTR_W-1:0]    wr_ptr_r;
  cmd_t                cmd_r;
  logic [DATA_W-1:0]   data_r;
  logic [AMT_W-1:0]    amt_r;
  logic [DATA_W-1:0]   res_val_r;
  logic                res_found_r;
  logic                res_drop_r;
  logic [PTR_W-1:0]    off_r;
  logic [PTR_W-1:0]    src_r;
  logic [PTR_W-1:0]    dst_r;
  logic [PTR_W-1:0]    pidx_r;
  logic                pend_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_value_r;
  logic [PTR_W-1:0]    out_pos_r;
  logic                out_found_r;
  logic                out_drop_r;
  logic [PTR_W-1:0]    out_used_r;
  logic [PTR_W-1:0]    out_free_r;

  logic [PTR_W-1:0]    cap;
  logic [PTR_W-1:0]    new_cap;
  logic [PTR_W-1:0]    cfg_wp;
  logic [SUM_W-1:0]    sum0;
  logic [SUM_W-1:0]    sum1;
  logic [SUM_W-1:0]    wsum;
  logic                hit0;
  logic                hit1;
  logic                room;
  logic                src_more;
  logic                out_free_slot;
  logic [BYTE_W-1:0]   first_byte;
  logic [BYTE_W-1:0]   second_byte;
  logic [BYTE_W-1:0]   get_byte;
  logic [PTR_W-1:0]    res_pos;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  // Capacity in effect, current and after a pending configuration write.
  assign cap     = (bsize_r > DEPTH_CAP) ? DEPTH_CAP : bsize_r;
  assign new_cap = (cfg_wr_data > DEPTH_CAP) ? DEPTH_CAP : cfg_wr_data;
  assign cfg_wp  = (wr_ptr_r > new_cap) ? new_cap : wr_ptr_r;

  // Address arithmetic for gets, advances and discard.
  assign sum0     = SUM_W'(rd_ptr_r) + SUM_W'(amt_r);
  assign sum1     = sum0 + SUM_W'(1);
  assign wsum     = SUM_W'(wr_ptr_r) + SUM_W'(amt_r);
  assign hit0     = sum0 < SUM_W'(cap);
  assign hit1     = sum1 < SUM_W'(cap);
  assign room     = wr_ptr_r < cap;
  assign src_more = src_r < wr_ptr_r;

  // Byte order of word puts.
  assign first_byte  = (cmd_r == CMD_PUT_WORD_HI) ? data_r[15:8] : data_r[7:0];
  assign second_byte = (cmd_r == CMD_PUT_WORD_HI) ? data_r[7:0] : data_r[15:8];

  // Byte read for a get; out of range reads as zero.
  assign get_byte = ((state_r == S_GET1) ? hit0 : hit1) ? ram_rdata : '0;

  assign out_free_slot = !out_valid_r || out_ready;

  // Position reported per command: pointer after the step, search offset, used count for locate, or capacity.
  always_comb begin
    case (cmd_r)
      CMD_PUT_BYTE, CMD_PUT_WORD_LO, CMD_PUT_WORD_HI,
      CMD_ADV_WRITE, CMD_DISCARD:                      res_pos = wr_ptr_r;
      CMD_GET_BYTE, CMD_GET_WORD_LO, CMD_GET_WORD_HI,
      CMD_ADV_READ:                                    res_pos = rd_ptr_r;
      CMD_SEARCH:                                      res_pos = off_r;
      CMD_LOCATE:                                      res_pos = wr_ptr_r - rd_ptr_r;
      CMD_CLEAR:                                       res_pos = cap;
      default:                                         res_pos = '0;
    endcase
  end

  // Store port control per state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(wr_ptr_r);
    ram_wdata = first_byte;
    ram_re    = 1'b0;
    ram_raddr = AW'(src_r);
    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      S_EXEC: begin
        if (cmd_r == CMD_PUT_BYTE || cmd_r == CMD_PUT_WORD_LO ||
            cmd_r == CMD_PUT_WORD_HI) begin
          ram_we = room;
        end
        if (cmd_r == CMD_GET_BYTE || cmd_r == CMD_GET_WORD_LO ||
            cmd_r == CMD_GET_WORD_HI) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(sum0);
        end
      end
      S_PUT2: begin
        ram_we    = room;
        ram_wdata = second_byte;
      end
      S_GET1: begin
        ram_re    = (cmd_r != CMD_GET_BYTE);
        ram_raddr = AW'(sum1);
      end
      S_MOVE: begin
        ram_re    = src_more;
        ram_we    = pend_r;
        ram_waddr = AW'(dst_r);
        ram_wdata = ram_rdata;
      end
      S_SCAN: begin
        ram_re = src_more;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, pointers and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      bsize_r     <= BSIZE_RST;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one replaces it.
      if (out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == CLR_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r       <= cmd_t'(in_command);
            data_r      <= in_data_value;
            amt_r       <= in_amount;
            res_val_r   <= '0;
            res_found_r <= 1'b0;
            res_drop_r  <= 1'b0;
            off_r       <= '0;
            state_r     <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_OUT;
          case (cmd_r)
            CMD_PUT_BYTE, CMD_PUT_WORD_LO, CMD_PUT_WORD_HI: begin
              if (room) begin
                wr_ptr_r <= wr_ptr_r + PTR_W'(1);
              end
              res_drop_r <= !room;
              if (cmd_r != CMD_PUT_BYTE) begin
                state_r <= S_PUT2;
              end
            end
            CMD_GET_BYTE, CMD_GET_WORD_LO, CMD_GET_WORD_HI: begin
              state_r <= S_GET1;
            end
            CMD_ADV_READ: begin
              rd_ptr_r <= (sum0 > SUM_W'(wr_ptr_r)) ? wr_ptr_r : PTR_W'(sum0);
            end
            CMD_ADV_WRITE: begin
              wr_ptr_r <= (wsum > SUM_W'(cap)) ? cap : PTR_W'(wsum);
            end
            CMD_DISCARD: begin
              if (sum0 < SUM_W'(wr_ptr_r)) begin
                // Compact the rest down to address zero.
                if (sum0 != '0) begin
                  src_r   <= PTR_W'(sum0);
                  dst_r   <= '0;
                  pend_r  <= 1'b0;
                  state_r <= S_MOVE;
                end
              end else begin
                rd_ptr_r <= '0;
                wr_ptr_r <= '0;
              end
            end
            CMD_SEARCH, CMD_LOCATE: begin
              src_r   <= rd_ptr_r;
              pend_r  <= 1'b0;
              state_r <= S_SCAN;
            end
            CMD_CLEAR: begin
              rd_ptr_r <= '0;
              wr_ptr_r <= '0;
            end
            default: begin
            end
          endcase
        end
        S_PUT2: begin
          if (room) begin
            wr_ptr_r <= wr_ptr_r + PTR_W'(1);
          end else begin
            res_drop_r <= 1'b1;
          end
          state_r <= S_OUT;
        end
        S_GET1: begin
          res_val_r <= DATA_W'(get_byte);
          state_r   <= (cmd_r == CMD_GET_BYTE) ? S_OUT : S_GET2;
        end
        S_GET2: begin
          if (cmd_r == CMD_GET_WORD_LO) begin
            res_val_r <= {get_byte, res_val_r[7:0]};
          end else begin
            res_val_r <= {res_val_r[7:0], get_byte};
          end
          state_r <= S_OUT;
        end
        S_MOVE: begin
          // Read one byte ahead and write it down in the next cycle.
          if (src_more) begin
            src_r <= src_r + PTR_W'(1);
          end
          pend_r <= src_more;
          if (pend_r) begin
            dst_r <= dst_r + PTR_W'(1);
          end
          if (!src_more && !pend_r) begin
            wr_ptr_r <= dst_r;
            rd_ptr_r <= '0;
            state_r  <= S_OUT;
          end
        end
        S_SCAN: begin
          if (pend_r && ram_rdata == data_r[7:0]) begin
            res_found_r <= 1'b1;
            off_r       <= pidx_r - rd_ptr_r;
            if (cmd_r == CMD_LOCATE) begin
              rd_ptr_r <= pidx_r;
            end
            state_r <= S_OUT;
          end else if (!src_more && !pend_r) begin
            if (cmd_r == CMD_LOCATE) begin
              rd_ptr_r <= wr_ptr_r;
            end
            state_r <= S_OUT;
          end else begin
            if (src_more) begin
              src_r  <= src_r + PTR_W'(1);
              pidx_r <= src_r;
            end
            pend_r <= src_more;
          end
        end
        S_OUT: begin
          // Hand the result to the output register once it is free.
          if (out_free_slot) begin
            out_valid_r <= 1'b1;
            out_value_r <= res_val_r;
            out_pos_r   <= res_pos;
            out_found_r <= res_found_r;
            out_drop_r  <= res_drop_r;
            out_used_r  <= wr_ptr_r - rd_ptr_r;
            out_free_r  <= cap - wr_ptr_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // Capacity write clamps both pointers; the user must send it only while idle, the block does not enforce it.
      if (cfg_wr_en) begin
        bsize_r  <= cfg_wr_data;
        wr_ptr_r <= cfg_wp;
        rd_ptr_r <= (rd_ptr_r > cfg_wp) ? cfg_wp : rd_ptr_r;
      end
    end
  end

  lmbb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_position   = out_pos_r;
  assign out_found      = out_found_r;
  assign out_dropped    = out_drop_r;
  assign out_used_count = out_used_r;
  assign out_free_count = out_free_r;

  // The read pointer never passes the write pointer.
  assert property (@(posedge clk) disable iff (!rst_n) rd_ptr_r <= wr_ptr_r)
    else $error("read pointer beyond write pointer");

  // The write pointer never passes the capacity in effect.
  assert property (@(posedge clk) disable iff (!rst_n) wr_ptr_r <= cap)
    else $error("write pointer beyond capacity");

  // After an item is taken, no further item is taken until its result is out.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item taken while another is in work");

endmodule

### rtl/lmbb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module lmbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sim/tb_linear_message_byte_buffer.sv
// Self-checking testbench for linear_message_byte_buffer: a directed table, then random items.
// Depends on lmbb_pkg and the RTL; expectations are hand-written or from a predictor in this file.
`timescale 1ns / 1ps

module tb_linear_message_byte_buffer
  import lmbb_pkg::*;
();

  // Command codes the block leaves undefined; it must answer them with zero value, position and flags.
  localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = 4'd12;
  localparam logic [CMD_W-1:0] CMD_UNDEF_LAST  = 4'd15;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int TAIL_ITEMS      = 30;
  localparam int SETTLE_CYCLES   = 20;

  // One result item as the block reports it.
  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [PTR_W-1:0]  position;
    logic              found;
    logic              dropped;
    logic [PTR_W-1:0]  used_count;
    logic [PTR_W-1:0]  free_count;
  } result_t;

  // One input item, with an optional hand-written expected result.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data;
    logic [AMT_W-1:0]  amt;
    logic              typed;
    result_t           res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [PTR_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_command = '0;
  logic [DATA_W-1:0] in_data_value = '0;
  logic [AMT_W-1:0]  in_amount = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_read_value;
  logic [PTR_W-1:0]  out_position;
  logic              out_found;
  logic              out_dropped;
  logic [PTR_W-1:0]  out_used_count;
  logic [PTR_W-1:0]  out_free_count;

  // Predictor state: a copy of the store, both indexes and the capacity register.
  logic [BYTE_W-1:0] byte_image [DEPTH_DEF];
  int                rd_idx;
  int                wr_idx;
  int                size_reg;

  result_t   pending_results [$];
  stim_row_t directed_rows [$];
  int        fail_count = 0;
  bit        tx_idle_en = 1'b0;
  bit        rx_idle_en = 1'b0;
  int        stall_left = 0;

  linear_message_byte_buffer u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_data_value (in_data_value),
    .in_amount     (in_amount),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_value(out_read_value),
    .out_position  (out_position),
    .out_found     (out_found),
    .out_dropped   (out_dropped),
    .out_used_count(out_used_count),
    .out_free_count(out_free_count)
  );

  always #1 clk = ~clk;

  // The capacity in effect is the register saturated at the store depth.
  function automatic int cap_now();
    return (size_reg > DEPTH_DEF) ? DEPTH_DEF : size_reg;
  endfunction

  // Append one byte; returns 1 when the buffer is full and the byte is lost.
  function automatic bit put_byte(input logic [BYTE_W-1:0] b);
    if (wr_idx < cap_now()) begin
      byte_image[wr_idx] = b;
      wr_idx++;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Bytes at or past the capacity read as zero.
  function automatic logic [BYTE_W-1:0] get_byte(input int offs);
    int addr;
    addr = rd_idx + offs;
    if (addr >= cap_now()) return '0;
    return byte_image[addr];
  endfunction

  // Find the first copy of a byte in the content; offset is from the read index.
  function automatic bit scan_for(input logic [BYTE_W-1:0] b, output int offs);
    bit hit;
    hit = 1'b0;
    offs = 0;
    for (int i = rd_idx; i < wr_idx && !hit; i++) begin
      if (byte_image[i] == b) begin
        hit = 1'b1;
        offs = i - rd_idx;
      end
    end
    return hit;
  endfunction

  // Apply one accepted item to the predictor state and return its result.
  function automatic result_t buffer_step(input logic [CMD_W-1:0] cmd,
                                          input logic [DATA_W-1:0] data,
                                          input logic [AMT_W-1:0] amt);
    result_t r;
    bit      d2;
    int      offs;
    int      amt_i;
    r = '0;
    amt_i = int'(amt);
    case (cmd)
      CMD_PUT_BYTE: begin
        r.dropped  = put_byte(data[7:0]);
        r.position = PTR_W'(wr_idx);
      end
      CMD_PUT_WORD_LO: begin
        r.dropped  = put_byte(data[7:0]);
        d2         = put_byte(data[15:8]);
        r.dropped  = r.dropped | d2;
        r.position = PTR_W'(wr_idx);
      end
      CMD_PUT_WORD_HI: begin
        r.dropped  = put_byte(data[15:8]);
        d2         = put_byte(data[7:0]);
        r.dropped  = r.dropped | d2;
        r.position = PTR_W'(wr_idx);
      end
      CMD_GET_BYTE: begin
        r.read_value = {8'h00, get_byte(amt_i)};
        r.position   = PTR_W'(rd_idx);
      end
      CMD_GET_WORD_LO: begin
        r.read_value = {get_byte(amt_i + 1), get_byte(amt_i)};
        r.position   = PTR_W'(rd_idx);
      end
      CMD_GET_WORD_HI: begin
        r.read_value = {get_byte(amt_i), get_byte(amt_i + 1)};
        r.position   = PTR_W'(rd_idx);
      end
      CMD_ADV_READ: begin
        rd_idx = rd_idx + amt_i;
        if (rd_idx > wr_idx) rd_idx = wr_idx;
        r.position = PTR_W'(rd_idx);
      end
      CMD_ADV_WRITE: begin
        wr_idx = wr_idx + amt_i;
        if (wr_idx > cap_now()) wr_idx = cap_now();
        r.position = PTR_W'(wr_idx);
      end
      CMD_DISCARD: begin
        offs = rd_idx + amt_i;
        if (offs < wr_idx) begin
          // Compact the remaining bytes down to address zero.
          if (offs > 0) begin
            for (int i = 0; i < wr_idx - offs; i++) byte_image[i] = byte_image[i + offs];
            wr_idx = wr_idx - offs;
            rd_idx = 0;
          end
        end else begin
          rd_idx = 0;
          wr_idx = 0;
        end
        r.position = PTR_W'(wr_idx);
      end
      CMD_SEARCH: begin
        r.found    = scan_for(data[7:0], offs);
        r.position = PTR_W'(offs);
      end
      CMD_LOCATE: begin
        r.found = scan_for(data[7:0], offs);
        if (r.found) rd_idx = rd_idx + offs;
        else rd_idx = wr_idx;
        r.position = PTR_W'(wr_idx - rd_idx);
      end
      CMD_CLEAR: begin
        rd_idx     = 0;
        wr_idx     = 0;
        r.position = PTR_W'(cap_now());
      end
      default: begin
      end
    endcase
    r.used_count = PTR_W'(wr_idx - rd_idx);
    r.free_count = PTR_W'(cap_now() - wr_idx);
    return r;
  endfunction

  // A capacity write clamps the write index, then the read index.
  function automatic void apply_capacity(input logic [PTR_W-1:0] v);
    size_reg = int'(v);
    if (wr_idx > cap_now()) wr_idx = cap_now();
    if (rd_idx > wr_idx) rd_idx = wr_idx;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] cmd, input int data, input int amt);
    stim_row_t row;
    row       = '0;
    row.cmd   = cmd;
    row.data  = DATA_W'(data);
    row.amt   = AMT_W'(amt);
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [CMD_W-1:0] cmd, input int data, input int amt,
                           input int rv, input int pos, input int fnd, input int drp,
                           input int used, input int free);
    stim_row_t row;
    row                = '0;
    row.cmd            = cmd;
    row.data           = DATA_W'(data);
    row.amt            = AMT_W'(amt);
    row.typed          = 1'b1;
    row.res.read_value = DATA_W'(rv);
    row.res.position   = PTR_W'(pos);
    row.res.found      = fnd[0];
    row.res.dropped    = drp[0];
    row.res.used_count = PTR_W'(used);
    row.res.free_count = PTR_W'(free);
    directed_rows.push_back(row);
  endtask

  // Random item: mostly meaningful puts, reads, scans, advances, discards and clears, with some raw noise.
  function automatic stim_row_t next_random_item();
    stim_row_t row;
    int        pick;
    int        used;
    row      = '0;
    row.data = DATA_W'($urandom);
    row.amt  = AMT_W'($urandom);
    used     = wr_idx - rd_idx;
    pick     = int'($urandom_range(0, 99));
    if (pick < 35) begin
      row.cmd = CMD_W'($urandom_range(CMD_PUT_BYTE, CMD_PUT_WORD_HI));
    end else if (pick < 55) begin
      row.cmd = CMD_W'($urandom_range(CMD_GET_BYTE, CMD_GET_WORD_HI));
      if ($urandom_range(0, 7) != 0) row.amt = AMT_W'($urandom_range(0, used + 1));
    end else if (pick < 64) begin
      row.cmd = ($urandom_range(0, 1) == 0) ? CMD_SEARCH : CMD_LOCATE;
      // Usually look for a byte that is really in the content.
      if (used > 0 && $urandom_range(0, 9) < 7)
        row.data[7:0] = byte_image[rd_idx + int'($urandom_range(0, used - 1))];
    end else if (pick < 71) begin
      row.cmd = CMD_ADV_READ;
      if ($urandom_range(0, 7) != 0) row.amt = AMT_W'($urandom_range(0, 4));
    end else if (pick < 76) begin
      row.cmd = CMD_ADV_WRITE;
      if ($urandom_range(0, 9) != 0) row.amt = AMT_W'($urandom_range(0, 3));
    end else if (pick < 85) begin
      row.cmd = CMD_DISCARD;
      if ($urandom_range(0, 7) != 0) row.amt = AMT_W'($urandom_range(0, used));
    end else if (pick < 88) begin
      row.cmd = CMD_CLEAR;
    end else begin
      row.cmd = CMD_W'($urandom_range(0, 15));
    end
    return row;
  endfunction

  // Present one item and hold it until the block takes it; valid stays high on return.
  task automatic send_item(input stim_row_t row);
    result_t predicted;
    int      gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = int'($urandom_range(1, 13));
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= row.cmd;
    in_data_value <= row.data;
    in_amount     <= row.amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = buffer_step(row.cmd, row.data, row.amt);
    pending_results.push_back(row.typed ? row.res : predicted);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(input logic [PTR_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    apply_capacity(v);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver: random stall bursts while enabled, otherwise always ready.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= int'($urandom_range(1, 13)) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.read_value, out_read_value);
        check_field("position", want.position, out_position);
        check_field("found", want.found, out_found);
        check_field("dropped", want.dropped, out_dropped);
        check_field("used_count", want.used_count, out_used_count);
        check_field("free_count", want.free_count, out_free_count);
      end
    end
  end

  // Main sequence: reset, directed table, random phases, calm tail.
  initial begin
    logic [PTR_W-1:0] sizes [NUM_PHASES];
    for (int i = 0; i < DEPTH_DEF; i++) byte_image[i] = '0;
    rd_idx   = 0;
    wr_idx   = 0;
    size_reg = int'(BSIZE_RST);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset capacity of 1024 bytes.
    add_typed(CMD_GET_BYTE, 16'h0000, 0, 0, 0, 0, 0, 0, 1024);
    add_typed(CMD_GET_WORD_HI, 16'hFFFF, 4095, 0, 0, 0, 0, 0, 1024);
    add_typed(CMD_SEARCH, 16'h0000, 0, 0, 0, 0, 0, 0, 1024);
    add_typed(CMD_PUT_BYTE, 16'hFFA5, 4095, 0, 1, 0, 0, 1, 1023);
    add_typed(CMD_PUT_WORD_LO, 16'h1234, 0, 0, 3, 0, 0, 3, 1021);
    add_typed(CMD_PUT_WORD_HI, 16'hBEEF, 0, 0, 5, 0, 0, 5, 1019);
    add_typed(CMD_GET_BYTE, 16'h0000, 0, 16'h00A5, 0, 0, 0, 5, 1019);
    add_typed(CMD_GET_WORD_LO, 16'h0000, 1, 16'h1234, 0, 0, 0, 5, 1019);
    add_typed(CMD_GET_WORD_HI, 16'h0000, 3, 16'hBEEF, 0, 0, 0, 5, 1019);
    // A word straddling the end of the capacity reads its upper byte as zero.
    add_row(CMD_GET_WORD_LO, 16'h0000, 1023);
    add_typed(CMD_SEARCH, 16'h00EF, 0, 0, 4, 1, 0, 5, 1019);
    add_typed(CMD_ADV_READ, 16'h0000, 1, 0, 1, 0, 0, 4, 1019);
    add_typed(CMD_LOCATE, 16'h55BE, 0, 0, 2, 1, 0, 2, 1019);
    add_typed(CMD_DISCARD, 16'h0000, 1, 0, 1, 0, 0, 1, 1023);
    // A locate miss empties the buffer.
    add_typed(CMD_LOCATE, 16'h0077, 0, 0, 0, 0, 0, 0, 1023);
    add_row(CMD_ADV_READ, 16'h0000, 4095);
    add_typed(CMD_ADV_WRITE, 16'h0000, 4095, 0, 1024, 0, 0, 1023, 0);
    add_typed(CMD_PUT_BYTE, 16'h00FF, 0, 0, 1024, 0, 1, 1023, 0);
    add_row(CMD_DISCARD, 16'h0000, 0);
    // Only the first byte of this word fits.
    add_row(CMD_PUT_WORD_LO, 16'hFFFF, 0);
    add_typed(CMD_DISCARD, 16'h0000, 4095, 0, 0, 0, 0, 0, 1024);
    add_typed(CMD_DISCARD, 16'h0000, 0, 0, 0, 0, 0, 0, 1024);
    add_typed(CMD_UNDEF_FIRST, 16'hFFFF, 4095, 0, 0, 0, 0, 0, 1024);
    add_typed(CMD_UNDEF_LAST, 16'h5A5A, 7, 0, 0, 0, 0, 0, 1024);
    add_typed(CMD_CLEAR, 16'h0000, 0, 0, 1024, 0, 0, 0, 1024);
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // Random phases, each under its own capacity; the extremes come first.
    sizes[0] = PTR_W'(PTR_MAX);
    sizes[1] = '0;
    sizes[2] = PTR_W'(16);
    sizes[3] = PTR_W'(1);
    sizes[4] = PTR_W'(DEPTH_DEF);
    sizes[5] = PTR_W'($urandom_range(2, 64));
    sizes[6] = PTR_W'($urandom_range(DEPTH_DEF + 1, PTR_MAX));
    sizes[7] = PTR_W'($urandom_range(0, 96));
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      tx_idle_en = (ph % 3 != 2);
      rx_idle_en <= (ph % 3 != 1);
      write_capacity(sizes[ph]);
      repeat (ITEMS_PER_PHASE) send_item(next_random_item());
    end

    // Final stretch with no idling on either side.
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    repeat (TAIL_ITEMS) send_item(next_random_item());
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
rtl/lmbb_pkg.sv
rtl/lmbb_ram.sv
rtl/linear_message_byte_buffer.sv
sim/tb_linear_message_byte_buffer.sv
